>>> rtl/core/lpdf_pkg.sv
// Shared constants, types and state codes of the lidar pulse distance filter.
package lpdf_pkg;

  // Group size of the spread test and the integer widths that follow from the fields.
  localparam int GROUP_SIZE = 3;
  localparam int CNT_W      = 2;
  localparam int SAMPLE_W   = 16;
  localparam int CAPTURE_W  = 16;
  localparam int WRAPS_W    = 8;
  localparam int TICKS_W    = CAPTURE_W + WRAPS_W;
  localparam int TPU_W      = 8;
  localparam int LIMIT_W    = 16;
  localparam int SUM_W      = 18;
  localparam int SQ_W       = 34;
  localparam int MUL_W      = 20;
  localparam int WIDE_W     = 2 * MUL_W;
  localparam int DIV_STEPS  = TICKS_W;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // Mean by reciprocal multiply: floor(sum * MEAN_RECIP / 2^MEAN_SHIFT) equals floor(sum / N).
  localparam int MEAN_SHIFT = 20;
  localparam int MEAN_RECIP = ((1 << MEAN_SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE;

  // Depth of the two word queues.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  // Configuration register indexes and reset values.
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_UNIT  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVIATION_LIMIT = 1'd1;
  localparam logic [TPU_W-1:0]     TPU_RESET           = 8'd24;
  localparam logic [LIMIT_W-1:0]   LIMIT_RESET         = 16'd200;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SQUARE,
    ST_ACCUM,
    ST_SUMSQ,
    ST_LIMSQ,
    ST_COMPARE,
    ST_MEAN
  } back_state_e;

  // Handshake between the front queue and the back end.
  typedef struct packed {
    logic               valid;
    logic [TICKS_W-1:0] ticks;
  } ticks_word_t;

endpackage

>>> rtl/core/lpdf_front.sv
// Front end: takes pulse captures, forms the pulse width in ticks and queues it.
module lpdf_front (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [lpdf_pkg::CAPTURE_W-1:0]  rising_capture_i,
  input  logic [lpdf_pkg::CAPTURE_W-1:0]  falling_capture_i,
  input  logic [lpdf_pkg::WRAPS_W-1:0]    overflow_count_i,
  output lpdf_pkg::ticks_word_t           word_o,
  input  logic                            pop_i
);
  import lpdf_pkg::*;

  logic [TICKS_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic [TICKS_W-1:0] hi_ticks, width_ticks;
  logic               do_push, do_pop;

  // Pulse width; an end stamp below the start stamp counts as zero ticks.
  assign hi_ticks    = {overflow_count_i, falling_capture_i};
  assign width_ticks = (hi_ticks >= TICKS_W'(rising_capture_i))
                       ? hi_ticks - TICKS_W'(rising_capture_i) : '0;

  assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop_i && (count_q != '0);

  assign word_o.valid = (count_q != '0);
  assign word_o.ticks = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= width_ticks;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/lpdf_back.sv
// Back end: serial divide to a distance sample, group accumulation and spread test.
module lpdf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lpdf_pkg::ticks_word_t         word_i,
  output logic                          pop_o,
  input  logic [lpdf_pkg::TPU_W-1:0]    ticks_per_unit_i,
  input  logic [lpdf_pkg::LIMIT_W-1:0]  deviation_limit_i,
  output logic                          res_push_o,
  output logic [lpdf_pkg::SAMPLE_W-1:0] res_mean_o,
  input  logic                          res_full_i
);
  import lpdf_pkg::*;

  back_state_e         state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic [TPU_W-1:0]    rem_q, rem_d, divisor_q, divisor_d;
  logic [TICKS_W-1:0]  quo_q, quo_d;
  logic [SAMPLE_W-1:0] sample_q, sample_d;
  logic [SUM_W-1:0]    sum_q, sum_d, base_sum;
  logic [SQ_W-1:0]     sq_q, sq_d, base_sq;
  logic [CNT_W-1:0]    count_q, count_d, base_count;
  logic [WIDE_W-1:0]   spread_q, spread_d, prod_q, bound;
  logic [MUL_W-1:0]    mul_a, mul_b;
  logic [WIDE_W-1:0]   mul_p;
  logic [TPU_W:0]      rem_shift, rem_sub;
  logic                rem_ge;
  logic [TICKS_W-1:0]  quo_next;

  // One restoring divide step.
  assign rem_shift = {rem_q, quo_q[TICKS_W-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor_q};
  assign rem_ge    = (rem_shift >= {1'b0, divisor_q});
  assign quo_next  = {quo_q[TICKS_W-2:0], rem_ge};

  // A stray count restarts the group before the new sample goes in.
  assign base_sum   = (count_q >= CNT_W'(GROUP_SIZE)) ? '0 : sum_q;
  assign base_sq    = (count_q >= CNT_W'(GROUP_SIZE)) ? '0 : sq_q;
  assign base_count = (count_q >= CNT_W'(GROUP_SIZE)) ? '0 : count_q;

  assign bound = prod_q * WIDE_W'(GROUP_SIZE * GROUP_SIZE);
  assign mul_p = mul_a * mul_b;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      sum_q   <= '0;
      sq_q    <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      sum_q   <= sum_d;
      sq_q    <= sq_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    step_q    <= step_d;
    rem_q     <= rem_d;
    quo_q     <= quo_d;
    divisor_q <= divisor_d;
    sample_q  <= sample_d;
    spread_q  <= spread_d;
    prod_q    <= mul_p;
  end

  // Next state, shared multiplier operands and outputs.
  always_comb begin
    state_d    = state_q;
    step_d     = step_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    divisor_d  = divisor_q;
    sample_d   = sample_q;
    spread_d   = spread_q;
    sum_d      = sum_q;
    sq_d       = sq_q;
    count_d    = count_q;
    mul_a      = '0;
    mul_b      = '0;
    pop_o      = 1'b0;
    res_push_o = 1'b0;
    res_mean_o = prod_q[MEAN_SHIFT +: SAMPLE_W];
    case (state_q)
      ST_IDLE: begin
        if (word_i.valid) begin
          pop_o     = 1'b1;
          quo_d     = word_i.ticks;
          rem_d     = '0;
          step_d    = '0;
          divisor_d = (ticks_per_unit_i == '0) ? TPU_W'(1) : ticks_per_unit_i;
          state_d   = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        rem_d  = rem_ge ? rem_sub[TPU_W-1:0] : rem_shift[TPU_W-1:0];
        quo_d  = quo_next;
        step_d = step_q + STEP_W'(1);
        if (step_q == STEP_W'(DIV_STEPS - 1)) begin
          // Saturate the quotient to the sample range.
          sample_d = (quo_next[TICKS_W-1:SAMPLE_W] != '0) ? '1 : quo_next[SAMPLE_W-1:0];
          state_d  = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        mul_a   = MUL_W'(sample_q);
        mul_b   = MUL_W'(sample_q);
        state_d = ST_ACCUM;
      end
      ST_ACCUM: begin
        sum_d   = base_sum + SUM_W'(sample_q);
        sq_d    = base_sq + prod_q[SQ_W-1:0];
        count_d = base_count + CNT_W'(1);
        state_d = ((base_count + CNT_W'(1)) < CNT_W'(GROUP_SIZE)) ? ST_IDLE : ST_SUMSQ;
      end
      ST_SUMSQ: begin
        mul_a   = MUL_W'(sum_q);
        mul_b   = MUL_W'(sum_q);
        state_d = ST_LIMSQ;
      end
      ST_LIMSQ: begin
        spread_d = WIDE_W'(sq_q) * WIDE_W'(GROUP_SIZE) - prod_q;
        mul_a    = MUL_W'(deviation_limit_i);
        mul_b    = MUL_W'(deviation_limit_i);
        state_d  = ST_COMPARE;
      end
      ST_COMPARE: begin
        mul_a = MUL_W'(sum_q);
        mul_b = MUL_W'(MEAN_RECIP);
        if (spread_q < bound) begin
          state_d = ST_MEAN;
        end else begin
          // Rejected group: restart without a result.
          sum_d   = '0;
          sq_d    = '0;
          count_d = '0;
          state_d = ST_IDLE;
        end
      end
      ST_MEAN: begin
        // Keep the mean product in place while the result queue is full.
        mul_a = MUL_W'(sum_q);
        mul_b = MUL_W'(MEAN_RECIP);
        if (!res_full_i) begin
          res_push_o = 1'b1;
          sum_d      = '0;
          sq_d       = '0;
          count_d    = '0;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // The group count never passes the group size.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(GROUP_SIZE)) else $error("group count above group size");

  // Between items the group is never complete.
  a_idle_open_group: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (count_q < CNT_W'(GROUP_SIZE)))
    else $error("complete group left in idle");

  // The partial remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> (rem_q < divisor_q)) else $error("remainder out of range");

  // A result word leaves only from the mean state and only into free space.
  a_push_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |-> ((state_q == ST_MEAN) && !res_full_i)) else $error("stray result push");

endmodule

>>> rtl/core/lpdf_out_queue.sv
// Result queue: holds finished mean distances until the receiver takes them.
module lpdf_out_queue (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  input  logic [lpdf_pkg::SAMPLE_W-1:0] data_i,
  output logic                          full_o,
  output logic                          empty,
  input  logic                          pop,
  output logic [lpdf_pkg::SAMPLE_W-1:0] data_o
);
  import lpdf_pkg::*;

  logic [SAMPLE_W-1:0] mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]   count_q;
  logic                do_push, do_pop;

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign empty   = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop && !empty;
  assign data_o  = mem_q[rd_ptr_q];

  // Queue storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   count_q <= count_q + QCNT_W'(1);
        2'b01:   count_q <= count_q - QCNT_W'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

>>> rtl/core/lidar_pulse_distance_filter_unit.sv
// Usage notes:
// The block turns lidar pulse captures into distance samples and, for every group of
// three samples whose spread is below the limit, delivers the truncated mean.
// Input channel: drive the three capture fields and raise push; a word is taken at a
// clock edge with push high and full low. Result channel: while empty is low the
// oldest mean is on distance_mean_o and is taken at an edge with pop high.
// Configuration: cfg_we_i writes cfg_wdata_i into register cfg_idx_i (0: ticks per
// unit, 1: deviation limit); write only while the block holds no work.
// Sequence: the back end takes one sample at a time, from its idle state; each sample
// passes the 24-step serial divider, then the square and accumulate steps. The sample
// that completes a group adds sum square, limit square, compare and mean steps on one
// shared multiplier; a rejected group ends after compare. The mean step pushes the
// result once the result queue has space.
// A two-word queue before and after the back end absorbs short bursts.
// Reset empties both queues, clears the group and loads 24 ticks per unit and a
// limit of 200. When the receiver stalls, finished words wait in the result queue;
// once it is full the back end holds, and the input queue then raises full.
module lidar_pulse_distance_filter_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            push,
  output logic                            full,
  input  logic [lpdf_pkg::CAPTURE_W-1:0]  rising_capture_i,
  input  logic [lpdf_pkg::CAPTURE_W-1:0]  falling_capture_i,
  input  logic [lpdf_pkg::WRAPS_W-1:0]    overflow_count_i,
  output logic                            empty,
  input  logic                            pop,
  output logic [lpdf_pkg::SAMPLE_W-1:0]   distance_mean_o,
  input  logic                            cfg_we_i,
  input  logic [lpdf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lpdf_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import lpdf_pkg::*;

  logic [TPU_W-1:0]    tpu_q;
  logic [LIMIT_W-1:0]  limit_q;
  ticks_word_t         front_word;
  logic                front_pop;
  logic                res_push, res_full;
  logic [SAMPLE_W-1:0] res_mean;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q   <= TPU_RESET;
      limit_q <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TICKS_PER_UNIT:  tpu_q   <= cfg_wdata_i[TPU_W-1:0];
        REG_DEVIATION_LIMIT: limit_q <= cfg_wdata_i[LIMIT_W-1:0];
        default: begin
          tpu_q <= tpu_q;
        end
      endcase
    end
  end

  // Capture and width queue.
  lpdf_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .push              (push),
    .full              (full),
    .rising_capture_i  (rising_capture_i),
    .falling_capture_i (falling_capture_i),
    .overflow_count_i  (overflow_count_i),
    .word_o            (front_word),
    .pop_i             (front_pop)
  );

  // Divider, accumulator and spread test.
  lpdf_back u_back (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .word_i            (front_word),
    .pop_o             (front_pop),
    .ticks_per_unit_i  (tpu_q),
    .deviation_limit_i (limit_q),
    .res_push_o        (res_push),
    .res_mean_o        (res_mean),
    .res_full_i        (res_full)
  );

  // Result queue toward the receiver.
  lpdf_out_queue u_out_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (res_mean),
    .full_o (res_full),
    .empty  (empty),
    .pop    (pop),
    .data_o (distance_mean_o)
  );

endmodule

>>> bench/tb_top.sv
// Testbench of the lidar pulse distance filter: directed pulses, random pulse groups, checks.
`timescale 1ns / 100ps

module tb_top;
  import lpdf_pkg::*;

  // Run limits and waits in clock cycles, phase sizes and the directed row count.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 200;
  localparam int LONG_HOLD     = 1500;
  localparam int PHASE_COUNT   = 8;
  localparam int PHASE_PULSES  = 160;
  localparam int DIRECTED_ROWS = 24;

  // One directed pulse; a typed row carries the result read straight off the spec.
  typedef struct packed {
    logic [CAPTURE_W-1:0] rise;
    logic [CAPTURE_W-1:0] fall;
    logic [WRAPS_W-1:0]   wraps;
    logic                 typed;
    logic                 emits;
    logic [SAMPLE_W-1:0]  mean;
  } pulse_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [CAPTURE_W-1:0] rising_capture = '0;
  logic [CAPTURE_W-1:0] falling_capture = '0;
  logic [WRAPS_W-1:0] overflow_count = '0;
  logic empty;
  logic pop = 1'b0;
  logic [SAMPLE_W-1:0] distance_mean;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // Predictor copy of the configuration and of the group being gathered.
  logic [TPU_W-1:0] model_tpu = TPU_RESET;
  logic [LIMIT_W-1:0] model_limit = LIMIT_RESET;
  logic [CNT_W-1:0] grp_count = '0;
  logic [SUM_W-1:0] grp_sum = '0;
  logic [SQ_W-1:0] grp_sq = '0;

  logic [SAMPLE_W-1:0] expected_means[$];
  int unsigned mismatches = 0;
  int unsigned cycles = 0;
  int unsigned burst_left = 8;
  logic hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  pulse_row_t directed_pulses[DIRECTED_ROWS];

  lidar_pulse_distance_filter_unit DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .push              (push),
    .full              (full),
    .rising_capture_i  (rising_capture),
    .falling_capture_i (falling_capture),
    .overflow_count_i  (overflow_count),
    .empty             (empty),
    .pop               (pop),
    .distance_mean_o   (distance_mean),
    .cfg_we_i          (cfg_we),
    .cfg_idx_i         (cfg_idx),
    .cfg_wdata_i       (cfg_wdata)
  );

  // Clock with a 2 ns period.
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Receiver: switches between stall patterns and obeys a requested long hold.
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle % 64 == 0) begin
      rx_mode <= $urandom_range(0, 2);
    end
    if (hold_req) begin
      hold_left <= LONG_HOLD;
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      pop <= 1'b0;
    end else begin
      case (rx_mode)
        0: pop <= 1'b1;
        1: pop <= $urandom_range(0, 1);
        default: pop <= (rx_cycle % 4 == 3);
      endcase
    end
  end

  // Result checker: every popped word is matched against the oldest expected mean.
  always @(posedge clk) begin
    if (rst_n && !empty && pop) begin
      if (expected_means.size() == 0) begin
        $error("distance_mean: no result expected, got %0d", distance_mean);
        mismatches <= mismatches + 1;
      end else begin
        if (distance_mean !== expected_means[0]) begin
          $error("distance_mean: expected %0d, got %0d", expected_means[0], distance_mean);
          mismatches <= mismatches + 1;
        end
        void'(expected_means.pop_front());
      end
    end
  end

  // Turns one pulse into a distance sample, folds it into the group and decides the result.
  task automatic fold_pulse(input logic [CAPTURE_W-1:0] rise, input logic [CAPTURE_W-1:0] fall,
                            input logic [WRAPS_W-1:0] wraps, output logic emits,
                            output logic [SAMPLE_W-1:0] mean);
    logic [TICKS_W:0] span;
    logic [TICKS_W-1:0] ticks;
    logic [TICKS_W-1:0] quotient;
    logic [TPU_W-1:0] divisor;
    logic [SAMPLE_W-1:0] sample;
    logic [63:0] spread;
    logic [63:0] bound;
    span = {1'b0, wraps, fall};
    ticks = (span >= {9'd0, rise}) ? TICKS_W'(span - {9'd0, rise}) : '0;
    divisor = (model_tpu == '0) ? TPU_W'(1) : model_tpu;
    quotient = ticks / divisor;
    sample = (quotient > TICKS_W'(16'hFFFF)) ? 16'hFFFF : quotient[SAMPLE_W-1:0];
    // A count left at or past the group size restarts the group first.
    if (grp_count >= CNT_W'(GROUP_SIZE)) begin
      grp_count = '0;
      grp_sum = '0;
      grp_sq = '0;
    end
    grp_sum = grp_sum + SUM_W'(sample);
    grp_sq = SQ_W'(64'(grp_sq) + 64'(sample) * 64'(sample));
    grp_count = grp_count + 1'b1;
    emits = 1'b0;
    mean = '0;
    // Group complete: exact integer spread test, then the truncated mean.
    if (grp_count == CNT_W'(GROUP_SIZE)) begin
      spread = 64'(GROUP_SIZE) * 64'(grp_sq) - 64'(grp_sum) * 64'(grp_sum);
      bound = 64'(GROUP_SIZE * GROUP_SIZE) * 64'(model_limit) * 64'(model_limit);
      emits = (spread < bound);
      mean = SAMPLE_W'(64'(grp_sum) / 64'(GROUP_SIZE));
      grp_count = '0;
      grp_sum = '0;
      grp_sq = '0;
    end
  endtask

  // Offers one pulse word, waits until it is taken, records what it should cause.
  task automatic send_pulse(input logic [CAPTURE_W-1:0] rise, input logic [CAPTURE_W-1:0] fall,
                            input logic [WRAPS_W-1:0] wraps, input logic typed,
                            input logic typed_emits, input logic [SAMPLE_W-1:0] typed_mean);
    logic emits;
    logic [SAMPLE_W-1:0] mean;
    push <= 1'b1;
    rising_capture <= rise;
    falling_capture <= fall;
    overflow_count <= wraps;
    @(posedge clk);
    while (full) @(posedge clk);
    fold_pulse(rise, fall, wraps, emits, mean);
    if (typed) begin
      emits = typed_emits;
      mean = typed_mean;
    end
    if (emits) expected_means.push_back(mean);
    // Bursts of random length, separated by random gaps.
    if (burst_left == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end else begin
      burst_left--;
    end
  endtask

  // Builds capture fields that yield the wanted distance sample under the current divisor.
  task automatic send_distance(input int unsigned sample);
    int unsigned divisor;
    int unsigned ticks;
    int unsigned headroom;
    int unsigned rise;
    int unsigned total;
    divisor = (model_tpu == '0) ? 1 : int'(model_tpu);
    ticks = sample * divisor + $urandom_range(0, divisor - 1);
    if (sample == 65535 && $urandom_range(0, 1) == 1) begin
      ticks = ticks + $urandom_range(0, 16711679 - ticks);
    end
    headroom = 16777215 - ticks;
    rise = $urandom_range(0, (headroom < 65535) ? headroom : 65535);
    total = rise + ticks;
    send_pulse(16'(rise), total[15:0], total[23:16], 1'b0, 1'b0, '0);
  endtask

  // One group of three pulses of a randomly chosen kind.
  task automatic send_group();
    int unsigned kind;
    int unsigned width;
    int unsigned base;
    int unsigned level;
    kind = $urandom_range(0, 99);
    width = 3 * int'(model_limit) + 2;
    if (width > 65535) width = 65535;
    base = $urandom_range(0, 65535 - width);
    level = ($urandom_range(0, 3) == 0) ? 65535 : $urandom_range(0, 65535);
    for (int i = 0; i < GROUP_SIZE; i++) begin
      if (kind < 60) begin
        // Spread straddling the limit, so groups both pass and fail.
        send_distance(base + $urandom_range(0, width));
      end else if (kind < 80) begin
        send_distance(level);
      end else begin
        send_pulse(16'($urandom), 16'($urandom), 8'($urandom), 1'b0, 1'b0, '0);
      end
    end
  endtask

  // Waits until every expected word has been popped.
  task automatic drain_results();
    while (expected_means.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_TICKS_PER_UNIT) model_tpu = data[TPU_W-1:0];
    else if (idx == REG_DEVIATION_LIMIT) model_limit = data[LIMIT_W-1:0];
    @(posedge clk);
  endtask

  // Main sequence: reset, directed pulses, then random groups under several settings.
  initial begin
    logic [TPU_W-1:0] tpu_set[PHASE_COUNT];
    logic [LIMIT_W-1:0] limit_set[PHASE_COUNT];
    pulse_row_t row;
    tpu_set = '{8'd1, 8'd255, 8'd0, 8'd7, 8'd24, 8'd128, 8'd3, 8'd200};
    limit_set = '{16'd65535, 16'd0, 16'd1000, 16'd50, 16'd200, 16'd5000, 16'd1, 16'd300};

    // Groups of three: all zero, negative widths, saturated, rejected, exact mean,
    // limit boundary just inside and just outside, and alternating bit patterns.
    directed_pulses = '{
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b1, 16'd0},
      '{16'd100,   16'd50,    8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd65535, 16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd65535, 16'd65534, 8'd0,   1'b1, 1'b1, 16'd0},
      '{16'd0,     16'd65535, 8'd255, 1'b1, 1'b0, 16'd0},
      '{16'd65535, 16'd65535, 8'd255, 1'b1, 1'b0, 16'd0},
      '{16'd1,     16'd0,     8'd255, 1'b1, 1'b1, 16'd65535},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd65535, 8'd255, 1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd2400,  8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd2400,  8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd2424,  8'd0,   1'b1, 1'b1, 16'd100},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd10176, 8'd0,   1'b1, 1'b1, 16'd141},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd0,     8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd0,     16'd10200, 8'd0,   1'b1, 1'b0, 16'd0},
      '{16'd65535, 16'd0,     8'd1,   1'b0, 1'b0, 16'd0},
      '{16'h5555,  16'hAAAA,  8'h55,  1'b0, 1'b0, 16'd0},
      '{16'hAAAA,  16'h5555,  8'hAA,  1'b0, 1'b0, 16'd0}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < DIRECTED_ROWS; r++) begin
      row = directed_pulses[r];
      send_pulse(row.rise, row.fall, row.wraps, row.typed, row.emits, row.mean);
    end

    for (int p = 0; p < PHASE_COUNT; p++) begin
      // The block must be idle before its registers change.
      push <= 1'b0;
      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clk);
      write_reg(REG_TICKS_PER_UNIT, {8'($urandom), tpu_set[p]});
      write_reg(REG_DEVIATION_LIMIT, limit_set[p]);
      // First phase passes every group: hold the receiver long enough to back up the input.
      if (p == 0) begin
        hold_req <= 1'b1;
        @(posedge clk);
        hold_req <= 1'b0;
      end
      for (int g = 0; g < PHASE_PULSES / GROUP_SIZE; g++) begin
        send_group();
        if ($urandom_range(0, 39) == 0) begin
          push <= 1'b0;
          drain_results();
          @(posedge clk);
        end
      end
    end

    push <= 1'b0;
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_means.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/core/lpdf_pkg.sv
rtl/core/lpdf_front.sv
rtl/core/lpdf_back.sv
rtl/core/lpdf_out_queue.sv
rtl/core/lidar_pulse_distance_filter_unit.sv
bench/tb_top.sv
